@@ sv/isf_pkg.sv @@
// shared types, constants and command codes for the inverse-square field sum
package isf_pkg;

    localparam int COORD_BITS = 24;
    localparam int MAX_ATTRACTORS = 16;
    localparam int STR_W = 32;
    localparam int FLOOR_W = 16;
    localparam int FIELD_W = 48;
    localparam int DIR_W = 16;
    localparam int IDX_FIELD_W = 4;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 16'd1;

    localparam int STEP_W = 6;
    localparam int DIV_STEPS = 32;
    localparam int SQRT_STEPS = 32;
    localparam int CDIV_STEPS = 47;
    localparam int DIR_STEPS = 15;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                          command;
        logic [IDX_FIELD_W-1:0]        entry_index;
        logic                          entry_enable;
        logic signed [COORD_BITS-1:0]  pos_x;
        logic signed [COORD_BITS-1:0]  pos_y;
        logic signed [COORD_BITS-1:0]  pos_z;
        logic [STR_W-1:0]              strength;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] field_x;
        logic signed [FIELD_W-1:0] field_y;
        logic signed [FIELD_W-1:0] field_z;
        logic [FIELD_W-1:0]        field_magnitude;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
    } out_item_t;

    typedef enum logic [4:0] {
        DP_NONE,
        DP_WRITE,
        DP_LOAD_SAMPLE,
        DP_DIFF,
        DP_D2,
        DP_DIV_STEP,
        DP_SQRT_LOAD_R,
        DP_SQRT_STEP,
        DP_MUL,
        DP_CDIV_LOAD,
        DP_CDIV_STEP,
        DP_ACC,
        DP_NORM_LOAD,
        DP_NORM_STEP,
        DP_SQUARE,
        DP_SQRT_LOAD_M,
        DP_MAG,
        DP_DIR_LOAD,
        DP_DIR_STEP,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
        logic norm_big;
    } dp_status_t;

endpackage

@@ sv/isf_ram.sv @@
// generic single write port ram with registered read
module isf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/isf_datapath.sv @@
// attractor table, divide units, a shared root unit, accumulators and output register
module isf_datapath #(
    parameter int MAX_ATTRACTORS = isf_pkg::MAX_ATTRACTORS,
    parameter int IDX_W = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  isf_pkg::dp_cmd_t               cmd,
    input  logic [IDX_W-1:0]               entry,
    input  isf_pkg::in_item_t              in_item,
    input  logic                           cfg_we,
    input  logic [isf_pkg::FLOOR_W-1:0]    cfg_data,
    output isf_pkg::dp_status_t            status,
    output isf_pkg::out_item_t             out_item
);

    localparam int CW = isf_pkg::COORD_BITS;
    localparam int DW = CW + 1;
    localparam int SW = isf_pkg::STR_W;
    localparam int FW = isf_pkg::FIELD_W;
    localparam int ENT_W = 3 * CW + SW;
    localparam int DIR_W_L = isf_pkg::DIR_W;

    logic [MAX_ATTRACTORS-1:0] valid_reg;
    logic [isf_pkg::FLOOR_W-1:0] floor_reg;

    logic [2:0][CW-1:0] samp_reg;
    logic [2:0][15:0]   adx_reg;
    logic [2:0]         neg_reg;
    logic               far_reg;
    logic               en_reg;
    logic [SW-1:0]      str_reg;
    logic [33:0]        d2_reg;
    logic [31:0]        dq_reg;
    logic [33:0]        drem_reg;
    logic [63:0]        sv_reg;
    logic [33:0]        srem_reg;
    logic [31:0]        root_reg;
    logic [2:0][31:0]   p_reg;
    logic [2:0][46:0]   cq_reg;
    logic [2:0][31:0]   crem_reg;
    logic [2:0][FW-1:0] acc_reg;
    logic [2:0][FW-1:0] na_reg;
    logic [4:0]         shift_reg;
    logic [2:0][61:0]   sq_reg;
    logic [FW-1:0]      mag_reg;
    logic [2:0][FW-1:0] rrem_reg;
    logic [2:0]         ovf_reg;
    logic [2:0][14:0]   qd_reg;
    isf_pkg::out_item_t out_reg;

    logic              ram_we;
    logic [ENT_W-1:0]  ram_rdata;
    logic [2:0][CW-1:0] ent_pos;
    logic [2:0][DW-1:0] diff_c;
    logic [2:0][DW-1:0] adiff_c;
    logic [2:0][31:0]  sqd_c;
    logic [34:0]       dshift_c;
    logic [35:0]       st_c;
    logic [35:0]       trial_c;
    logic [2:0][47:0]  prod_c;
    logic [2:0][32:0]  cshift_c;
    logic [2:0][FW-1:0] fabs_c;
    logic [2:0][FW:0]  rshift_c;
    logic [FW-1:0]     mag_c;
    logic [2:0][14:0]  dmag_c;
    logic [2:0][DIR_W_L-1:0] dir_c;

    assign ram_we = (cmd.op == isf_pkg::DP_WRITE)
                    && (int'(in_item.entry_index) < MAX_ATTRACTORS);

    isf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ATTRACTORS),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(in_item.entry_index)),
        .wdata ({in_item.pos_x, in_item.pos_y, in_item.pos_z, in_item.strength}),
        .raddr (entry),
        .rdata (ram_rdata)
    );

    assign ent_pos[0] = ram_rdata[ENT_W-1 -: CW];
    assign ent_pos[1] = ram_rdata[ENT_W-CW-1 -: CW];
    assign ent_pos[2] = ram_rdata[ENT_W-2*CW-1 -: CW];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff_c[i] = DW'(signed'(ent_pos[i])) - DW'(signed'(samp_reg[i]));
            adiff_c[i] = diff_c[i][DW-1] ? (DW'(0) - diff_c[i]) : diff_c[i];
            sqd_c[i] = adx_reg[i] * adx_reg[i];
            prod_c[i] = dq_reg * adx_reg[i];
            cshift_c[i] = {crem_reg[i], cq_reg[i][46]};
            fabs_c[i] = acc_reg[i][FW-1] ? (FW'(0) - acc_reg[i]) : acc_reg[i];
            rshift_c[i] = {rrem_reg[i], 1'b0};
            dmag_c[i] = ovf_reg[i] ? 15'h7fff : qd_reg[i];
            if (mag_reg == '0)
            begin
                dir_c[i] = '0;
            end
            else if (acc_reg[i][FW-1])
            begin
                dir_c[i] = DIR_W_L'(0) - {1'b0, dmag_c[i]};
            end
            else
            begin
                dir_c[i] = {1'b0, dmag_c[i]};
            end
        end
        dshift_c = {drem_reg, dq_reg[31]};
        st_c = {srem_reg, sv_reg[63:62]};
        trial_c = {2'b00, root_reg, 2'b01};
        mag_c = {16'b0, root_reg} << shift_reg;
    end

    // table valid flags and floor register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            floor_reg <= isf_pkg::FLOOR_RESET;
        end
        else
        begin
            if (ram_we)
            begin
                valid_reg[IDX_W'(in_item.entry_index)] <= in_item.entry_enable;
            end
            if (cfg_we)
            begin
                floor_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            isf_pkg::DP_LOAD_SAMPLE:
            begin
                samp_reg[0] <= in_item.pos_x;
                samp_reg[1] <= in_item.pos_y;
                samp_reg[2] <= in_item.pos_z;
                acc_reg <= '0;
            end
            isf_pkg::DP_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    adx_reg[i] <= adiff_c[i][15:0];
                    neg_reg[i] <= diff_c[i][DW-1];
                end
                far_reg <= (|adiff_c[0][DW-1:16]) || (|adiff_c[1][DW-1:16])
                           || (|adiff_c[2][DW-1:16]);
                en_reg <= valid_reg[entry];
                str_reg <= ram_rdata[SW-1:0];
            end
            isf_pkg::DP_D2:
            begin
                d2_reg <= 34'(sqd_c[0]) + 34'(sqd_c[1]) + 34'(sqd_c[2]);
                dq_reg <= str_reg;
                drem_reg <= '0;
            end
            isf_pkg::DP_DIV_STEP:
            begin
                if (dshift_c >= {1'b0, d2_reg})
                begin
                    drem_reg <= 34'(dshift_c - {1'b0, d2_reg});
                    dq_reg <= {dq_reg[30:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dshift_c[33:0];
                    dq_reg <= {dq_reg[30:0], 1'b0};
                end
            end
            isf_pkg::DP_SQRT_LOAD_R:
            begin
                sv_reg <= {d2_reg, 30'b0};
                srem_reg <= '0;
                root_reg <= '0;
            end
            isf_pkg::DP_SQRT_STEP:
            begin
                sv_reg <= {sv_reg[61:0], 2'b00};
                if (st_c >= trial_c)
                begin
                    srem_reg <= 34'(st_c - trial_c);
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    srem_reg <= st_c[33:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            isf_pkg::DP_MUL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p_reg[i] <= prod_c[i][31:0];
                end
            end
            isf_pkg::DP_CDIV_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    cq_reg[i] <= {p_reg[i], 15'b0};
                    crem_reg[i] <= '0;
                end
            end
            isf_pkg::DP_CDIV_STEP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (cshift_c[i] >= {1'b0, root_reg})
                    begin
                        crem_reg[i] <= 32'(cshift_c[i] - {1'b0, root_reg});
                        cq_reg[i] <= {cq_reg[i][45:0], 1'b1};
                    end
                    else
                    begin
                        crem_reg[i] <= cshift_c[i][31:0];
                        cq_reg[i] <= {cq_reg[i][45:0], 1'b0};
                    end
                end
            end
            isf_pkg::DP_ACC:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (neg_reg[i])
                    begin
                        acc_reg[i] <= acc_reg[i] - FW'(cq_reg[i]);
                    end
                    else
                    begin
                        acc_reg[i] <= acc_reg[i] + FW'(cq_reg[i]);
                    end
                end
            end
            isf_pkg::DP_NORM_LOAD:
            begin
                na_reg <= fabs_c;
                shift_reg <= '0;
            end
            isf_pkg::DP_NORM_STEP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    na_reg[i] <= {1'b0, na_reg[i][FW-1:1]};
                end
                shift_reg <= shift_reg + 5'd1;
            end
            isf_pkg::DP_SQUARE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[i] <= na_reg[i][30:0] * na_reg[i][30:0];
                end
            end
            isf_pkg::DP_SQRT_LOAD_M:
            begin
                sv_reg <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
                srem_reg <= '0;
                root_reg <= '0;
            end
            isf_pkg::DP_MAG:
            begin
                mag_reg <= mag_c;
            end
            isf_pkg::DP_DIR_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rrem_reg[i] <= fabs_c[i];
                    ovf_reg[i] <= fabs_c[i] >= mag_reg;
                    qd_reg[i] <= '0;
                end
            end
            isf_pkg::DP_DIR_STEP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rshift_c[i] >= {1'b0, mag_reg})
                    begin
                        rrem_reg[i] <= FW'(rshift_c[i] - {1'b0, mag_reg});
                        qd_reg[i] <= {qd_reg[i][13:0], 1'b1};
                    end
                    else
                    begin
                        rrem_reg[i] <= rshift_c[i][FW-1:0];
                        qd_reg[i] <= {qd_reg[i][13:0], 1'b0};
                    end
                end
            end
            isf_pkg::DP_OUT:
            begin
                out_reg.field_x <= acc_reg[0];
                out_reg.field_y <= acc_reg[1];
                out_reg.field_z <= acc_reg[2];
                out_reg.field_magnitude <= mag_reg;
                out_reg.dir_x <= dir_c[0];
                out_reg.dir_y <= dir_c[1];
                out_reg.dir_z <= dir_c[2];
            end
            default:
            begin
            end
        endcase
    end

    assign status.skip = !en_reg || far_reg || (d2_reg == '0)
                         || (dq_reg <= {16'b0, floor_reg});
    assign status.norm_big = (|na_reg[0][FW-1:31]) || (|na_reg[1][FW-1:31])
                             || (|na_reg[2][FW-1:31]);
    assign out_item = out_reg;

endmodule

@@ sv/isf_ctrl.sv @@
// sequencer for table writes, the per-entry walk and the final normalization
module isf_ctrl #(
    parameter int MAX_ATTRACTORS = isf_pkg::MAX_ATTRACTORS,
    parameter int IDX_W = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 in_command,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  isf_pkg::dp_status_t  status,
    output isf_pkg::dp_cmd_t     cmd,
    output logic [IDX_W-1:0]     entry
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_D2,
        S_DIV,
        S_CHK,
        S_SQRT_R,
        S_MUL,
        S_CDLD,
        S_CDIV,
        S_ACC,
        S_ADV,
        S_NORM_LD,
        S_NORM,
        S_SQUARE,
        S_SQLD,
        S_SQRT_M,
        S_MAG,
        S_DIRLD,
        S_DIR,
        S_OUT
    } state_t;

    localparam int SW = isf_pkg::STEP_W;

    state_t                     state_reg, state_next;
    logic [SW-1:0]              step_reg, step_next;
    logic [IDX_W-1:0]           entry_reg, entry_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       in_take;

    assign in_take = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        entry_next = entry_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op = isf_pkg::DP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (in_command == isf_pkg::CMD_QUERY)
                    begin
                        cmd.op = isf_pkg::DP_LOAD_SAMPLE;
                        entry_next = '0;
                        state_next = S_READ;
                    end
                    else
                    begin
                        cmd.op = isf_pkg::DP_WRITE;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.op = isf_pkg::DP_DIFF;
                state_next = S_D2;
            end
            S_D2:
            begin
                cmd.op = isf_pkg::DP_D2;
                step_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = isf_pkg::DP_DIV_STEP;
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(isf_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                cmd.op = isf_pkg::DP_SQRT_LOAD_R;
                step_next = '0;
                state_next = status.skip ? S_ADV : S_SQRT_R;
            end
            S_SQRT_R:
            begin
                cmd.op = isf_pkg::DP_SQRT_STEP;
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(isf_pkg::SQRT_STEPS - 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.op = isf_pkg::DP_MUL;
                state_next = S_CDLD;
            end
            S_CDLD:
            begin
                cmd.op = isf_pkg::DP_CDIV_LOAD;
                step_next = '0;
                state_next = S_CDIV;
            end
            S_CDIV:
            begin
                cmd.op = isf_pkg::DP_CDIV_STEP;
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(isf_pkg::CDIV_STEPS - 1))
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.op = isf_pkg::DP_ACC;
                state_next = S_ADV;
            end
            S_ADV:
            begin
                if (entry_reg == IDX_W'(MAX_ATTRACTORS - 1))
                begin
                    state_next = S_NORM_LD;
                end
                else
                begin
                    entry_next = entry_reg + IDX_W'(1);
                    state_next = S_READ;
                end
            end
            S_NORM_LD:
            begin
                cmd.op = isf_pkg::DP_NORM_LOAD;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (status.norm_big)
                begin
                    cmd.op = isf_pkg::DP_NORM_STEP;
                end
                else
                begin
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.op = isf_pkg::DP_SQUARE;
                state_next = S_SQLD;
            end
            S_SQLD:
            begin
                cmd.op = isf_pkg::DP_SQRT_LOAD_M;
                step_next = '0;
                state_next = S_SQRT_M;
            end
            S_SQRT_M:
            begin
                cmd.op = isf_pkg::DP_SQRT_STEP;
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(isf_pkg::SQRT_STEPS - 1))
                begin
                    state_next = S_MAG;
                end
            end
            S_MAG:
            begin
                cmd.op = isf_pkg::DP_MAG;
                state_next = S_DIRLD;
            end
            S_DIRLD:
            begin
                cmd.op = isf_pkg::DP_DIR_LOAD;
                step_next = '0;
                state_next = S_DIR;
            end
            S_DIR:
            begin
                cmd.op = isf_pkg::DP_DIR_STEP;
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(isf_pkg::DIR_STEPS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op = isf_pkg::DP_OUT;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= '0;
            entry_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            entry_reg <= entry_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign entry = entry_reg;

endmodule

@@ sv/inverse_square_field_sum.sv @@
// top level of the inverse-square field sum
// write item: taken while idle, no result
// query: every entry gets a 32-step divide; one that is disabled, out of range, at zero
//   distance or below the floor is then skipped, one that contributes adds a 32-step root
//   and a 47-step component divide; normalization then gives magnitude and direction
// one item at a time; reset empties the table and sets the floor to 1, no clearing pass
module inverse_square_field_sum #(
    parameter int MAX_ATTRACTORS = isf_pkg::MAX_ATTRACTORS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  isf_pkg::in_item_t            in_item,
    output logic                         out_valid,
    input  logic                         out_stall,
    output isf_pkg::out_item_t           out_item,
    input  logic                         cfg_we,
    input  logic [isf_pkg::FLOOR_W-1:0]  cfg_data
);

    localparam int IDX_W = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;

    isf_pkg::dp_cmd_t    cmd;
    isf_pkg::dp_status_t status;
    logic [IDX_W-1:0]    entry;

    isf_ctrl #(
        .MAX_ATTRACTORS (MAX_ATTRACTORS),
        .IDX_W          (IDX_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_command (in_item.command),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .cmd        (cmd),
        .entry      (entry)
    );

    isf_datapath #(
        .MAX_ATTRACTORS (MAX_ATTRACTORS),
        .IDX_W          (IDX_W)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .entry    (entry),
        .in_item  (in_item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .status   (status),
        .out_item (out_item)
    );

endmodule

@@ tb/tb_inverse_square_field_sum.sv @@
// testbench for the inverse-square field sum: directed and random items checked against a predictor
`timescale 1ns / 1ps

module tb_inverse_square_field_sum;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int HOLD_CYCLES = 4000;
    localparam int SETTLE_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    isf_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    isf_pkg::out_item_t out_item;
    logic cfg_we = 1'b0;
    logic [isf_pkg::FLOOR_W-1:0] cfg_data = '0;

    inverse_square_field_sum u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [isf_pkg::FLOOR_W-1:0] floor_value = isf_pkg::FLOOR_RESET;
    logic att_on [isf_pkg::MAX_ATTRACTORS];
    logic signed [isf_pkg::COORD_BITS-1:0] att_x [isf_pkg::MAX_ATTRACTORS];
    logic signed [isf_pkg::COORD_BITS-1:0] att_y [isf_pkg::MAX_ATTRACTORS];
    logic signed [isf_pkg::COORD_BITS-1:0] att_z [isf_pkg::MAX_ATTRACTORS];
    logic [isf_pkg::STR_W-1:0] att_str [isf_pkg::MAX_ATTRACTORS];

    isf_pkg::out_item_t expected_fields [$];
    int error_count = 0;
    int idle_cycles = 0;
    bit sender_gaps = 1'b1;
    bit receiver_gaps = 1'b1;
    int hold_count = 0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint axis_pull(longint unsigned inten, longint d,
                                         longint unsigned r);
        longint unsigned m;
        m = ((inten * abs64(d)) << 15) / r;
        return (d < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp_field(longint v);
        if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
        return v;
    endfunction

    function automatic logic [isf_pkg::DIR_W-1:0] unit_axis(longint f, longint unsigned mag);
        longint unsigned q;
        if (mag == 0) return '0;
        q = (abs64(f) << 15) / mag;
        if (q > 32767) q = 32767;
        if (f < 0) q = 0 - q;
        return q[isf_pkg::DIR_W-1:0];
    endfunction

    // applies a write item to the table; returns 1 with the field for a query
    function automatic bit field_at(isf_pkg::in_item_t it, output isf_pkg::out_item_t res);
        longint fx, fy, fz, dx, dy, dz;
        longint unsigned d2, inten, r, ax, ay, az, m, sum, mag;
        int s;
        fx = 0; fy = 0; fz = 0;
        res = '0;
        if (it.command == isf_pkg::CMD_WRITE)
        begin
            att_on[it.entry_index] = it.entry_enable;
            att_x[it.entry_index] = it.pos_x;
            att_y[it.entry_index] = it.pos_y;
            att_z[it.entry_index] = it.pos_z;
            att_str[it.entry_index] = it.strength;
            return 1'b0;
        end
        for (int i = 0; i < isf_pkg::MAX_ATTRACTORS; i++)
        begin
            if (!att_on[i]) continue;
            dx = longint'(att_x[i]) - longint'(it.pos_x);
            dy = longint'(att_y[i]) - longint'(it.pos_y);
            dz = longint'(att_z[i]) - longint'(it.pos_z);
            if (abs64(dx) >= 65536 || abs64(dy) >= 65536 || abs64(dz) >= 65536) continue;
            d2 = abs64(dx) * abs64(dx) + abs64(dy) * abs64(dy) + abs64(dz) * abs64(dz);
            if (d2 == 0) continue;
            inten = longint'(att_str[i]) / d2;
            if (inten <= longint'(floor_value)) continue;
            r = int_sqrt(d2 << 30);
            fx += axis_pull(inten, dx, r);
            fy += axis_pull(inten, dy, r);
            fz += axis_pull(inten, dz, r);
        end
        fx = clamp_field(fx);
        fy = clamp_field(fy);
        fz = clamp_field(fz);
        ax = abs64(fx); ay = abs64(fy); az = abs64(fz);
        m = ax;
        if (ay > m) m = ay;
        if (az > m) m = az;
        s = 0;
        while ((m >> s) >= (64'd1 << 31)) s++;
        ax = ax >> s; ay = ay >> s; az = az >> s;
        sum = ax * ax + ay * ay + az * az;
        mag = int_sqrt(sum) << s;
        if (mag > 64'hFFFF_FFFF_FFFF) mag = 64'hFFFF_FFFF_FFFF;
        res.field_x = fx[isf_pkg::FIELD_W-1:0];
        res.field_y = fy[isf_pkg::FIELD_W-1:0];
        res.field_z = fz[isf_pkg::FIELD_W-1:0];
        res.field_magnitude = mag[isf_pkg::FIELD_W-1:0];
        res.dir_x = unit_axis(fx, mag);
        res.dir_y = unit_axis(fy, mag);
        res.dir_z = unit_axis(fz, mag);
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        isf_pkg::out_item_t want;
        if (out_valid && !out_stall)
        begin
            if (expected_fields.size() == 0)
            begin
                report_mismatch("unexpected result item", out_item.field_x, 0);
            end
            else
            begin
                want = expected_fields.pop_front();
                if (out_item.field_x !== want.field_x)
                    report_mismatch("field_x", out_item.field_x, want.field_x);
                if (out_item.field_y !== want.field_y)
                    report_mismatch("field_y", out_item.field_y, want.field_y);
                if (out_item.field_z !== want.field_z)
                    report_mismatch("field_z", out_item.field_z, want.field_z);
                if (out_item.field_magnitude !== want.field_magnitude)
                    report_mismatch("field_magnitude", out_item.field_magnitude,
                                    want.field_magnitude);
                if (out_item.dir_x !== want.dir_x)
                    report_mismatch("dir_x", out_item.dir_x, want.dir_x);
                if (out_item.dir_y !== want.dir_y)
                    report_mismatch("dir_y", out_item.dir_y, want.dir_y);
                if (out_item.dir_z !== want.dir_z)
                    report_mismatch("dir_z", out_item.dir_z, want.dir_z);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver stall
    initial
    begin
        int burst;
        forever
        begin
            @(negedge clk);
            if (hold_count > 0)
            begin
                out_stall = 1'b1;
                hold_count--;
            end
            else if (receiver_gaps && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 17);
                out_stall = 1'b1;
                repeat (burst - 1) @(negedge clk);
            end
            else
            begin
                out_stall = 1'b0;
            end
        end
    end

    task automatic send_item(isf_pkg::in_item_t it);
        isf_pkg::out_item_t res;
        if (sender_gaps && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 17)) @(negedge clk);
        in_item = it;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        if (field_at(it, res)) expected_fields.push_back(res);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_fields.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_floor(logic [isf_pkg::FLOOR_W-1:0] value);
        wait_drained();
        cfg_data = value;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        floor_value = value;
    endtask

    function automatic isf_pkg::in_item_t make_item(bit cmd, int idx, bit en, longint x,
                                                    longint y, longint z,
                                                    longint unsigned str);
        isf_pkg::in_item_t it;
        it.command = cmd ? isf_pkg::CMD_QUERY : isf_pkg::CMD_WRITE;
        it.entry_index = idx[isf_pkg::IDX_FIELD_W-1:0];
        it.entry_enable = en;
        it.pos_x = x[isf_pkg::COORD_BITS-1:0];
        it.pos_y = y[isf_pkg::COORD_BITS-1:0];
        it.pos_z = z[isf_pkg::COORD_BITS-1:0];
        it.strength = str[isf_pkg::STR_W-1:0];
        return it;
    endfunction

    function automatic isf_pkg::in_item_t cluster_item(longint cx, longint cy, longint cz);
        int span;
        longint unsigned str;
        span = ($urandom_range(0, 3) == 0) ? 70000 : 300;
        case ($urandom_range(0, 3))
            0: str = $urandom;
            1: str = 32'hFFFF_FFFF;
            default: str = $urandom_range(0, 32'h00FF_FFFF);
        endcase
        return make_item($urandom_range(0, 9) < 6, $urandom_range(0, 15),
                         $urandom_range(0, 4) != 0,
                         cx + $signed($urandom_range(0, 2 * span)) - span,
                         cy + $signed($urandom_range(0, 2 * span)) - span,
                         cz + $signed($urandom_range(0, 2 * span)) - span, str);
    endfunction

    function automatic isf_pkg::in_item_t noise_item();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(isf_pkg::in_item_t)-1:0];
    endfunction

    task automatic run_random(int count);
        longint cx, cy, cz;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                cx = $signed($urandom_range(0, 16000000)) - 8000000;
                cy = $signed($urandom_range(0, 16000000)) - 8000000;
                cz = $signed($urandom_range(0, 16000000)) - 8000000;
            end
            if ($urandom_range(0, 9) < 8) send_item(cluster_item(cx, cy, cz));
            else send_item(noise_item());
        end
    endtask

    task automatic test_directed();
        send_item(make_item(1, 0, 0, 0, 0, 0, 0));
        send_item(make_item(0, 0, 1, 1, 0, 0, 32'hFFFF_FFFF));
        send_item(make_item(1, 0, 0, 0, 0, 0, 0));
        send_item(make_item(0, 1, 1, 0, -2, 0, 32'h0001_0000));
        send_item(make_item(0, 2, 1, 0, 0, 0, 32'hFFFF_FFFF));
        send_item(make_item(0, 15, 1, -8388608, 8388607, -8388608, 32'hFFFF_FFFF));
        send_item(make_item(1, 15, 1, 0, 0, 0, 32'hFFFF_FFFF));
        send_item(make_item(1, 3, 0, 8388607, -8388608, 8388607, 0));
        send_item(make_item(1, 0, 0, -8388608, 8388607, -8388608, 0));
        send_item(make_item(0, 3, 1, 0, 0, 65535, 32'hFFFF_FFFF));
        send_item(make_item(0, 4, 1, 0, 65536, 0, 32'hFFFF_FFFF));
        send_item(make_item(0, 5, 1, -1, -1, -1, 32'hFFFF_FFFF));
        send_item(make_item(1, 0, 0, 0, 0, 0, 0));
        send_item(make_item(0, 6, 1, 3, 4, 0, 100));
        send_item(make_item(1, 0, 0, 0, 0, 0, 0));
        send_item(make_item(0, 0, 0, 1, 0, 0, 32'hFFFF_FFFF));
        send_item(make_item(0, 5, 0, 0, 0, 0, 0));
        send_item(make_item(1, 0, 0, 0, 0, 0, 0));
        send_item(make_item(1, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_floor_settings();
        write_floor(16'd0);
        run_random(60);
        write_floor(16'hFFFF);
        run_random(60);
        write_floor(16'd40);
        run_random(60);
        write_floor(isf_pkg::FLOOR_RESET);
    endtask

    task automatic test_backpressure();
        hold_count = HOLD_CYCLES;
        run_random(20);
        wait_drained();
        run_random(30);
    endtask

    task automatic test_quiet_tail();
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        run_random(60);
    endtask

    initial
    begin
        for (int i = 0; i < isf_pkg::MAX_ATTRACTORS; i++)
        begin
            att_on[i] = 1'b0;
            att_x[i] = '0;
            att_y[i] = '0;
            att_z[i] = '0;
            att_str[i] = '0;
        end
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_floor_settings();
        run_random(440);
        test_backpressure();
        test_quiet_tail();
        wait_drained();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/isf_pkg.sv
sv/isf_ram.sv
sv/isf_datapath.sv
sv/isf_ctrl.sv
sv/inverse_square_field_sum.sv
tb/tb_inverse_square_field_sum.sv
